// File: hdl/simon_128_256_block_cipher_unit_defines.svh
// assertion macros for the simon block cipher unit
`ifndef SIMON_128_256_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define SIMON_128_256_BLOCK_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SIMON_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("simon unit: same-cycle check failed");

// next-cycle implication, checked out of reset
`define SIMON_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("simon unit: next-cycle check failed");

`endif

// File: hdl/simon_pkg.sv
// shared types, constants, round function and key step of the simon 128/256 unit
package simon_pkg;

    localparam int ROUND_COUNT     = 72;
    localparam int KEY_TABLE_DEPTH = 72;
    localparam int WORD_W          = 64;
    localparam int KEY_AW          = $clog2(KEY_TABLE_DEPTH);
    localparam int CNT_W           = $clog2(ROUND_COUNT);
    localparam int Z4_PERIOD       = 62;
    localparam int ZIDX_W          = $clog2(Z4_PERIOD);
    localparam int PADDR_W         = 6;
    localparam int PDATA_W         = 64;
    localparam int KEY_WORDS       = 4;

    localparam logic [WORD_W-1:0] Z4_SEQ    = 64'h3DC94C3A046D678B;
    localparam logic [WORD_W-1:0] KEY_CONST = 64'd3;

    typedef enum logic [2:0] {
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_KEY3,
        REG_MODE
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND
    } t_state;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;
    localparam logic MODE_LINEAR = 1'b1;

    function automatic logic [WORD_W-1:0] rol1(input logic [WORD_W-1:0] x);
        rol1 = {x[WORD_W-2:0], x[WORD_W-1]};
    endfunction

    function automatic logic [WORD_W-1:0] rol2(input logic [WORD_W-1:0] x);
        rol2 = {x[WORD_W-3:0], x[WORD_W-1:WORD_W-2]};
    endfunction

    function automatic logic [WORD_W-1:0] rol8(input logic [WORD_W-1:0] x);
        rol8 = {x[WORD_W-9:0], x[WORD_W-1:WORD_W-8]};
    endfunction

    // round mixing term including the rotate-by-two
    function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x,
                                                  input logic mode);
        logic [WORD_W-1:0] f;
        f = (mode == MODE_LINEAR) ? rol1(x) : (rol1(x) & rol8(x));
        round_f = f ^ rol2(x);
    endfunction

    // one step of the four-word key schedule
    function automatic logic [WORD_W-1:0] key_step(input logic [WORD_W-1:0] k_m4,
                                                   input logic [WORD_W-1:0] k_m3,
                                                   input logic [WORD_W-1:0] k_m1,
                                                   input logic              zbit);
        logic [WORD_W-1:0] t;
        t = {k_m1[2:0], k_m1[WORD_W-1:3]} ^ k_m3;
        t = t ^ {t[0], t[WORD_W-1:1]};
        key_step = ~k_m4 ^ t ^ {{(WORD_W-1){1'b0}}, zbit} ^ KEY_CONST;
    endfunction

endpackage

// File: hdl/simon_ram.sv
// generic single-write, single-read ram with registered read data
module simon_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/simon_128_256_block_cipher_unit.sv
// simon 128/256 block cipher unit: config registers, key schedule and round sequencer
//
//  channel   | handshake                          | payload
//  ----------+------------------------------------+-----------------------------------
//  item in   | start & !busy                      | i_func, i_block_word0/1
//  result    | o_done, one-cycle strobe           | o_result_word0/1
//  config    | psel & penable & pwrite (pready=1) | paddr, pwdata, prdata (64 bit)
//
//  an item runs one key prefetch, then one feistel round per cycle through the shared
//  round unit, all while busy; o_done follows in the next cycle
//  after reset or a key register write the next item first runs the key schedule,
//  one round key written to the key ram per cycle
//  reset (synchronous, active low) clears keys, mode, sequencer and the expanded flag
//  the receiver cannot stall: the result is shown for exactly one cycle
`include "simon_128_256_block_cipher_unit_defines.svh"

module simon_128_256_block_cipher_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_func,
    input  logic [simon_pkg::WORD_W-1:0]         i_block_word0,
    input  logic [simon_pkg::WORD_W-1:0]         i_block_word1,
    // result channel
    output logic                                 o_done,
    output logic [simon_pkg::WORD_W-1:0]         o_result_word0,
    output logic [simon_pkg::WORD_W-1:0]         o_result_word1,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [simon_pkg::PADDR_W-1:0]        paddr,
    input  logic [simon_pkg::PDATA_W-1:0]        pwdata,
    output logic [simon_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [simon_pkg::WORD_W-1:0] r_key [simon_pkg::KEY_WORDS];
    logic                         r_mode;
    logic                         r_expanded;
    logic                         n_expanded;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    // registers sit on 8-byte boundaries
    assign cfg_idx = paddr[simon_pkg::PADDR_W-1:3];

    always_comb begin
        unique case (cfg_idx)
            simon_pkg::REG_KEY0: prdata = r_key[0];
            simon_pkg::REG_KEY1: prdata = r_key[1];
            simon_pkg::REG_KEY2: prdata = r_key[2];
            simon_pkg::REG_KEY3: prdata = r_key[3];
            simon_pkg::REG_MODE: prdata = {{(simon_pkg::PDATA_W-1){1'b0}}, r_mode};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key[0] <= '0;
            r_key[1] <= '0;
            r_key[2] <= '0;
            r_key[3] <= '0;
            r_mode   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                simon_pkg::REG_KEY0: r_key[0] <= pwdata;
                simon_pkg::REG_KEY1: r_key[1] <= pwdata;
                simon_pkg::REG_KEY2: r_key[2] <= pwdata;
                simon_pkg::REG_KEY3: r_key[3] <= pwdata;
                simon_pkg::REG_MODE: r_mode   <= pwdata[0];
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------
    simon_pkg::t_state r_state, n_state;

    logic                          accept;
    logic                          last_xidx;
    logic                          last_round;
    logic                          r_done;
    logic                          n_done;
    logic                          r_func;
    logic                          n_func;
    logic [simon_pkg::CNT_W-1:0]   r_cnt,  n_cnt;    // rounds done
    logic [simon_pkg::CNT_W-1:0]   r_xidx, n_xidx;   // key schedule index
    logic [simon_pkg::ZIDX_W-1:0]  r_zidx, n_zidx;   // z4 bit position
    logic [simon_pkg::KEY_AW-1:0]  r_kaddr, n_kaddr; // next round key to fetch

    // datapath
    logic [simon_pkg::WORD_W-1:0]  r_left,  n_left;
    logic [simon_pkg::WORD_W-1:0]  r_right, n_right;
    logic [simon_pkg::WORD_W-1:0]  r_win [simon_pkg::KEY_WORDS];  // last four round keys
    logic [simon_pkg::WORD_W-1:0]  new_key;
    logic [simon_pkg::WORD_W-1:0]  f_in;
    logic [simon_pkg::WORD_W-1:0]  f_out;

    // key ram port
    logic                          ram_wr_en;
    logic [simon_pkg::KEY_AW-1:0]  ram_wr_addr;
    logic [simon_pkg::KEY_AW-1:0]  ram_rd_addr;
    logic [simon_pkg::WORD_W-1:0]  ram_rd_data;

    assign accept     = start & ~busy;
    assign last_xidx  = (r_xidx == simon_pkg::CNT_W'(simon_pkg::ROUND_COUNT - 1));
    assign last_round = (r_cnt  == simon_pkg::CNT_W'(simon_pkg::ROUND_COUNT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            simon_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = r_expanded ? simon_pkg::ST_LOAD : simon_pkg::ST_EXPAND;
                end
            end
            simon_pkg::ST_EXPAND: begin
                if (last_xidx) begin
                    n_state = simon_pkg::ST_LOAD;
                end
            end
            simon_pkg::ST_LOAD: begin
                n_state = simon_pkg::ST_ROUND;
            end
            simon_pkg::ST_ROUND: begin
                if (last_round) begin
                    n_state = simon_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs: busy and key ram control
    always_comb begin
        busy        = 1'b1;
        ram_wr_en   = 1'b0;
        ram_wr_addr = simon_pkg::KEY_AW'(r_xidx);
        ram_rd_addr = r_kaddr;
        unique case (r_state)
            simon_pkg::ST_IDLE: begin
                busy = 1'b0;
            end
            simon_pkg::ST_EXPAND: begin
                ram_wr_en = 1'b1;
            end
            simon_pkg::ST_LOAD: begin
                ram_rd_addr = r_kaddr;
            end
            simon_pkg::ST_ROUND: begin
                ram_rd_addr = r_kaddr;
            end
        endcase
    end

    // first four schedule steps copy the key words, the rest run the recurrence
    always_comb begin
        if (r_xidx < simon_pkg::CNT_W'(simon_pkg::KEY_WORDS)) begin
            new_key = r_key[r_xidx[1:0]];
        end else begin
            new_key = simon_pkg::key_step(r_win[0], r_win[1], r_win[3],
                                          simon_pkg::Z4_SEQ[r_zidx]);
        end
    end

    // one shared round unit: encrypt mixes the right half, decrypt the left
    assign f_in  = (r_func == simon_pkg::FUNC_DEC) ? r_left : r_right;
    assign f_out = simon_pkg::round_f(f_in, r_mode);

    // register next values
    always_comb begin
        n_expanded = r_expanded;
        n_done     = 1'b0;
        n_func     = r_func;
        n_cnt      = r_cnt;
        n_xidx     = r_xidx;
        n_zidx     = r_zidx;
        n_kaddr    = r_kaddr;
        n_left     = r_left;
        n_right    = r_right;

        unique case (r_state)
            simon_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func  = i_func;
                    n_left  = i_block_word0;
                    n_right = i_block_word1;
                    n_cnt   = '0;
                    n_xidx  = '0;
                    n_zidx  = '0;
                    n_kaddr = (i_func == simon_pkg::FUNC_DEC)
                            ? simon_pkg::KEY_AW'(simon_pkg::ROUND_COUNT - 1) : '0;
                end
            end
            simon_pkg::ST_EXPAND: begin
                n_xidx = r_xidx + 1'b1;
                if (r_xidx >= simon_pkg::CNT_W'(simon_pkg::KEY_WORDS)) begin
                    n_zidx = (r_zidx == simon_pkg::ZIDX_W'(simon_pkg::Z4_PERIOD - 1))
                           ? '0 : r_zidx + 1'b1;
                end
                if (last_xidx) begin
                    n_expanded = 1'b1;
                end
            end
            simon_pkg::ST_LOAD: begin
                n_kaddr = (r_func == simon_pkg::FUNC_DEC) ? r_kaddr - 1'b1 : r_kaddr + 1'b1;
            end
            simon_pkg::ST_ROUND: begin
                if (r_func == simon_pkg::FUNC_DEC) begin
                    n_left  = r_right ^ f_out ^ ram_rd_data;
                    n_right = r_left;
                end else begin
                    n_right = r_left ^ f_out ^ ram_rd_data;
                    n_left  = r_right;
                end
                n_cnt = r_cnt + 1'b1;
                if (last_round) begin
                    n_done = 1'b1;
                end else if (r_func == simon_pkg::FUNC_DEC) begin
                    n_kaddr = r_kaddr - 1'b1;
                end else begin
                    n_kaddr = r_kaddr + 1'b1;
                end
            end
        endcase

        // key writes void the schedule; user must write keys only while idle, unchecked
        if (cfg_wr && (cfg_idx == simon_pkg::REG_KEY0 || cfg_idx == simon_pkg::REG_KEY1 ||
                       cfg_idx == simon_pkg::REG_KEY2 || cfg_idx == simon_pkg::REG_KEY3)) begin
            n_expanded = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= simon_pkg::ST_IDLE;
            r_expanded <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_xidx     <= '0;
            r_zidx     <= '0;
            r_kaddr    <= '0;
            r_func     <= simon_pkg::FUNC_ENC;
        end else begin
            r_state    <= n_state;
            r_expanded <= n_expanded;
            r_done     <= n_done;
            r_cnt      <= n_cnt;
            r_xidx     <= n_xidx;
            r_zidx     <= n_zidx;
            r_kaddr    <= n_kaddr;
            r_func     <= n_func;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_right <= n_right;
        if (r_state == simon_pkg::ST_EXPAND) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= new_key;
        end
    end

    // round key table
    simon_ram #(
        .WIDTH (simon_pkg::WORD_W),
        .DEPTH (simon_pkg::KEY_TABLE_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (new_key),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // result: halves hold until the next item is accepted
    assign o_done         = r_done;
    assign o_result_word0 = r_left;
    assign o_result_word1 = r_right;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the final round is always followed by a done strobe
    `SIMON_ASSERT_NEXT(a_last_round_done, (r_state == simon_pkg::ST_ROUND) && last_round, o_done)
    // a result is only shown once the unit is free again
    `SIMON_ASSERT_NOW(a_done_idle, o_done, !busy)
    // rounds never start on a stale key schedule
    `SIMON_ASSERT_NOW(a_load_expanded, r_state == simon_pkg::ST_LOAD, r_expanded)
    // an item on a valid schedule skips key expansion
    `SIMON_ASSERT_NEXT(a_skip_expand, accept && r_expanded, r_state == simon_pkg::ST_LOAD)

endmodule

// File: tb/simon_128_256_block_cipher_unit_checker.sv
// scoreboard with a cycle-free cipher predictor for the simon 128/256 unit
module simon_128_256_block_cipher_unit_checker
    import simon_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_func,
    input  logic [WORD_W-1:0]  i_block_word0,
    input  logic [WORD_W-1:0]  i_block_word1,
    input  logic               i_done,
    input  logic [WORD_W-1:0]  i_result_word0,
    input  logic [WORD_W-1:0]  i_result_word1,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_pending,
    output int                 o_fail_cnt
);

    typedef struct packed {
        logic [WORD_W-1:0] word0;
        logic [WORD_W-1:0] word1;
    } t_cipher_block;

    logic [WORD_W-1:0] key_reg [KEY_WORDS];
    logic              mode_reg;
    logic              schedule_valid;
    logic [WORD_W-1:0] round_key [ROUND_COUNT];
    t_cipher_block     predicted_blocks [$];
    t_cipher_block     want_block;
    int                reg_index;
    int                mismatch_count = 0;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    // nonlinear (or linear in mode 1) term plus the rotate by two
    function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] x,
                                                      input logic mode);
        logic [WORD_W-1:0] f;
        f = (mode == MODE_LINEAR) ? rotl(x, 1) : (rotl(x, 1) & rotl(x, 8));
        return f ^ rotl(x, 2);
    endfunction

    // four-word key schedule with the z4 sequence
    function automatic void expand_schedule();
        logic [WORD_W-1:0] t;
        for (int i = 0; i < KEY_WORDS; i++)
            round_key[i] = key_reg[i];
        for (int i = KEY_WORDS; i < ROUND_COUNT; i++) begin
            t = rotr(round_key[i-1], 3) ^ round_key[i-3];
            t = t ^ rotr(t, 1);
            round_key[i] = ~round_key[i-4] ^ t ^ WORD_W'(Z4_SEQ[(i-4) % Z4_PERIOD]) ^ KEY_CONST;
        end
        schedule_valid = 1'b1;
    endfunction

    function automatic t_cipher_block cipher_rounds(input logic func,
                                                    input logic [WORD_W-1:0] w0,
                                                    input logic [WORD_W-1:0] w1,
                                                    input logic mode);
        logic [WORD_W-1:0] x0;
        logic [WORD_W-1:0] x1;
        logic [WORD_W-1:0] t;
        t_cipher_block     res;
        x0 = w0;
        x1 = w1;
        if (func == FUNC_ENC) begin
            for (int r = 0; r < ROUND_COUNT; r++) begin
                t  = x1;
                x1 = x0 ^ feistel_mix(x1, mode) ^ round_key[r];
                x0 = t;
            end
        end else begin
            for (int r = ROUND_COUNT - 1; r >= 0; r--) begin
                t  = x0;
                x0 = x1 ^ feistel_mix(x0, mode) ^ round_key[r];
                x1 = t;
            end
        end
        res.word0 = x0;
        res.word1 = x1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_WORDS; k++)
                key_reg[k] = '0;
            mode_reg       = 1'b0;
            schedule_valid = 1'b0;
            predicted_blocks.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_index = int'(i_paddr) / 8;
                if (reg_index < KEY_WORDS) begin
                    key_reg[reg_index] = i_pwdata;
                    schedule_valid     = 1'b0;
                end else if (reg_index == REG_MODE) begin
                    mode_reg = i_pwdata[0];
                end
            end
            if (i_done) begin
                if (predicted_blocks.size() == 0) begin
                    $error("result with no item pending: result_word0 %h result_word1 %h",
                           i_result_word0, i_result_word1);
                    mismatch_count++;
                end else begin
                    want_block = predicted_blocks.pop_front();
                    if (i_result_word0 !== want_block.word0) begin
                        $error("result_word0 expected %h actual %h",
                               want_block.word0, i_result_word0);
                        mismatch_count++;
                    end
                    if (i_result_word1 !== want_block.word1) begin
                        $error("result_word1 expected %h actual %h",
                               want_block.word1, i_result_word1);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (!schedule_valid)
                    expand_schedule();
                predicted_blocks.push_back(cipher_rounds(i_func, i_block_word0,
                                                         i_block_word1, mode_reg));
            end
        end
        o_pending  <= predicted_blocks.size();
        o_fail_cnt <= mismatch_count;
    end

endmodule

// File: tb/simon_128_256_block_cipher_unit_tb.sv
// stimulus and verdict for the simon 128/256 block cipher unit
module simon_128_256_block_cipher_unit_tb;
    import simon_pkg::*;

    // register index past the last one, writes there must be dropped
    localparam int                SPARE_REG_IDX   = REG_MODE + 1;
    localparam logic [WORD_W-1:0] ALL_ONES        = '1;
    localparam logic [WORD_W-1:0] MSB_ONLY        = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] LSB_ONLY        = {{(WORD_W-1){1'b0}}, 1'b1};
    localparam logic [WORD_W-1:0] CHECKER_5       = {(WORD_W/4){4'h5}};
    localparam logic [WORD_W-1:0] CHECKER_A       = {(WORD_W/4){4'hA}};
    localparam int                RANDOM_PHASES   = 8;
    localparam int                ITEMS_PER_PHASE = 85;
    // a late strobe after the last result would show within one item time
    localparam int                DRAIN_CYCLES    = 2 * ROUND_COUNT + 8;

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               i_func        = FUNC_ENC;
    logic [WORD_W-1:0]  i_block_word0 = '0;
    logic [WORD_W-1:0]  i_block_word1 = '0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic               busy;
    logic               o_done;
    logic [WORD_W-1:0]  o_result_word0;
    logic [WORD_W-1:0]  o_result_word1;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 pending_items;
    int                 fail_total;
    // random gaps between items on or off, so some stretches run back to back
    bit                 gaps_on = 1'b0;

    simon_128_256_block_cipher_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_block_word0  (i_block_word0),
        .i_block_word1  (i_block_word1),
        .o_done         (o_done),
        .o_result_word0 (o_result_word0),
        .o_result_word1 (o_result_word1),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    simon_128_256_block_cipher_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_block_word0  (i_block_word0),
        .i_block_word1  (i_block_word1),
        .i_done         (o_done),
        .i_result_word0 (o_result_word0),
        .i_result_word1 (o_result_word1),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending_items),
        .o_fail_cnt     (fail_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hard stop in case the unit hangs or drops a result
    initial begin
        #40_000_000;
        $display("simon_128_256_block_cipher_unit regression: fail");
        $finish;
    end

    // mostly back to back, some short gaps, a few long enough to cross
    // the done strobe and leave the unit idle for a while
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 4);
        if (roll < 96)
            return $urandom_range(5, 90);
        return $urandom_range(91, 220);
    endfunction

    // data word with the extremes mixed in now and then
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: begin
                return '0;
            end
            1: begin
                return ALL_ONES;
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    // apb write: setup cycle, access cycle, then psel and penable low again, so that
    // back to back writes never touch psel twice in one step
    task automatic write_reg(input int idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop start and wait until every result is back and the unit is quiet;
    // the first edge lets the checker count catch the last accepted item
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (busy || pending_items != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // present one item and hold it until start & !busy at an edge;
    // start stays high into the next item when no gap follows
    task automatic send_block(input logic func, input logic [WORD_W-1:0] w0,
                              input logic [WORD_W-1:0] w1);
        int gap;
        start         <= 1'b1;
        i_func        <= func;
        i_block_word0 <= w0;
        i_block_word1 <= w1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no key written yet: the first item expands the all-zero reset key
        send_block(FUNC_ENC, '0, '0);
        send_block(FUNC_DEC, '0, '0);
        send_block(FUNC_ENC, ALL_ONES, ALL_ONES);
        send_block(FUNC_DEC, ALL_ONES, ALL_ONES);
        wait_idle();

        // byte-pattern key, standard round function
        write_reg(REG_KEY0, 64'h0706050403020100);
        write_reg(REG_KEY1, 64'h0f0e0d0c0b0a0908);
        write_reg(REG_KEY2, 64'h1716151413121110);
        write_reg(REG_KEY3, 64'h1f1e1d1c1b1a1918);
        write_reg(REG_MODE, '0);
        send_block(FUNC_ENC, 64'h74206e69206d6f6f, 64'h6d69732061207369);
        send_block(FUNC_DEC, 64'h74206e69206d6f6f, 64'h6d69732061207369);
        send_block(FUNC_ENC, MSB_ONLY, LSB_ONLY);
        send_block(FUNC_DEC, LSB_ONLY, MSB_ONLY);
        send_block(FUNC_ENC, CHECKER_5, CHECKER_A);
        wait_idle();

        // linear variant, upper data bits set and ignored; no re-expansion
        write_reg(REG_MODE, ALL_ONES);
        send_block(FUNC_ENC, ALL_ONES, '0);
        send_block(FUNC_DEC, '0, ALL_ONES);
        send_block(FUNC_ENC, CHECKER_A, CHECKER_5);
        wait_idle();

        // back to standard with only bit 0 clear, plus a write past the map
        write_reg(REG_MODE, ~LSB_ONLY);
        write_reg(SPARE_REG_IDX, ALL_ONES);
        send_block(FUNC_ENC, 64'h74206e69206d6f6f, 64'h6d69732061207369);
        send_block(FUNC_DEC, MSB_ONLY, MSB_ONLY);
        wait_idle();

        // all-ones key in both modes
        write_reg(REG_KEY0, ALL_ONES);
        write_reg(REG_KEY1, ALL_ONES);
        write_reg(REG_KEY2, ALL_ONES);
        write_reg(REG_KEY3, ALL_ONES);
        send_block(FUNC_ENC, '0, '0);
        send_block(FUNC_DEC, ALL_ONES, ALL_ONES);
        wait_idle();
        write_reg(REG_MODE, LSB_ONLY);
        send_block(FUNC_ENC, LSB_ONLY, LSB_ONLY);
        send_block(FUNC_DEC, MSB_ONLY, LSB_ONLY);

        // random phases: fresh key words (some or all), random mode with
        // junk in the upper bits, then a burst of random items
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            for (int k = 0; k < KEY_WORDS; k++) begin
                if (phase == 0 || $urandom_range(0, 2) != 0)
                    write_reg(k, pick_word());
            end
            if (phase < 2 || $urandom_range(0, 1) != 0)
                write_reg(REG_MODE, {$urandom, $urandom});
            gaps_on = (phase % 4) != 3;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then let the unit run completely dry
                if ($urandom_range(0, 59) == 0)
                    wait_idle();
                send_block(1'($urandom_range(0, 1)), pick_word(), pick_word());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_total == 0)
            $display("simon_128_256_block_cipher_unit regression: pass");
        else
            $display("simon_128_256_block_cipher_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/simon_pkg.sv
hdl/simon_ram.sv
hdl/simon_128_256_block_cipher_unit.sv
tb/simon_128_256_block_cipher_unit_checker.sv
tb/simon_128_256_block_cipher_unit_tb.sv
